>>> sv/gbnsw_pkg.sv
// Shared types and codes for the Go-Back-N sender window.
// No dependencies; used by gbnsw_cell and go_back_n_sender_window.
`timescale 1ns / 1ps
`default_nettype none

package gbnsw_pkg;

    localparam int SEQ_W  = 5;
    localparam int WIN_W  = 5;
    localparam int OP_W   = 2;
    localparam int KIND_W = 2;
    localparam int CMD_W  = 3;

    // input operations
    localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SEND   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESEND = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    // commands broadcast along the cell chain
    localparam logic [CMD_W-1:0] CMD_HOLD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SHIFT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ROTATE = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic [SEQ_W-1:0] seq;
    } t_cell_cmd;

endpackage

`default_nettype wire

>>> sv/gbnsw_cell.sv
// One window entry of the sender chain: sequence number and acked mark.
// Depends on gbnsw_pkg for the command struct and codes.
`timescale 1ns / 1ps
`default_nettype none

module gbnsw_cell #(
    parameter int IDX = 0,
    parameter int PW  = 4,
    parameter int CW  = 5
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  gbnsw_pkg::t_cell_cmd         i_cmd,
    input  wire  [PW-1:0]                i_occ,
    input  wire  [CW:0]                  i_dist,
    input  wire  [gbnsw_pkg::SEQ_W-1:0]  i_next_seq,
    input  wire                          i_next_acked,
    input  wire  [gbnsw_pkg::SEQ_W-1:0]  i_head_seq,
    input  wire                          i_head_acked,
    output logic [gbnsw_pkg::SEQ_W-1:0]  o_seq,
    output logic                         o_acked
);

    logic [gbnsw_pkg::SEQ_W-1:0] r_seq;
    logic [gbnsw_pkg::SEQ_W-1:0] n_seq;
    logic                        r_acked;
    logic                        n_acked;

    always_comb begin
        n_seq   = r_seq;
        n_acked = r_acked;
        unique case (i_cmd.op)
            gbnsw_pkg::CMD_LOAD: begin
                if (IDX == int'(i_occ)) begin
                    n_seq   = i_cmd.seq;
                    n_acked = 1'b0;
                end
            end
            gbnsw_pkg::CMD_MARK: begin
                if (IDX < int'(i_occ) && IDX <= int'(i_dist)) begin
                    n_acked = 1'b1;
                end
            end
            gbnsw_pkg::CMD_SHIFT: begin
                n_seq   = i_next_seq;
                n_acked = i_next_acked;
            end
            gbnsw_pkg::CMD_ROTATE: begin
                // close the ring at the newest occupied entry
                if (IDX == int'(i_occ) - 1) begin
                    n_seq   = i_head_seq;
                    n_acked = i_head_acked;
                end else begin
                    n_seq   = i_next_seq;
                    n_acked = i_next_acked;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acked <= 1'b0;
        end else begin
            r_acked <= n_acked;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq <= n_seq;
    end

    assign o_seq   = r_seq;
    assign o_acked = r_acked;

endmodule

`default_nettype wire

>>> sv/go_back_n_sender_window.sv
// Top level of the Go-Back-N sender window: control sequencer and cell chain.
// Depends on gbnsw_pkg and gbnsw_cell.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high and
//   busy low; i_operation selects send, cumulative ack or timeout resend.
//   Results appear registered, one per cycle, flagged by o_result_valid for a
//   single cycle each; o_last marks the final result of a command. The receiver
//   cannot stall, so results are never held back.
//   The chain keeps entries in age order, oldest in cell 0; freeing shifts the
//   chain one entry per cycle and a resend rotates it one entry per cycle.
//   Per command:
//     send    : result registered, next command accepted the following cycle.
//     ack     : R (0..7) modulo-reduction steps of the ack and oldest sequence
//               against the sequence space, then F freed entries, then the result.
//     timeout : one result per cycle for each in-flight entry (1 if empty).
//   Writing i_cfg_wr_data (only while idle) sets window_size and flushes the
//   ring. Reset sets window_size to 16 with an empty ring.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_window #(
    parameter int WINDOW_MAX = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [gbnsw_pkg::OP_W-1:0]       i_operation,
    input  wire  [gbnsw_pkg::SEQ_W-1:0]      i_sequence_req,
    input  wire                              i_cfg_wr_en,
    input  wire  [gbnsw_pkg::WIN_W-1:0]      i_cfg_wr_data,
    output logic                             o_result_valid,
    output logic [gbnsw_pkg::KIND_W-1:0]     o_kind,
    output logic                             o_accepted,
    output logic [$clog2(WINDOW_MAX)-1:0]    o_slot,
    output logic [gbnsw_pkg::SEQ_W-1:0]      o_resend_sequence,
    output logic [$clog2(WINDOW_MAX)-1:0]    o_freed_count,
    output logic [$clog2(WINDOW_MAX)-1:0]    o_occupancy,
    output logic                             o_window_full,
    output logic                             o_window_empty,
    output logic                             o_last
);

    localparam int PW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = gbnsw_pkg::SEQ_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_FREE   = 3'd2;
    localparam logic [2:0] S_RESEND = 3'd3;

    logic [2:0]                   r_state, n_state;
    logic [gbnsw_pkg::WIN_W-1:0]  r_window_size, n_window_size;
    logic [PW-1:0]                r_occ, n_occ;
    logic [PW-1:0]                r_old, n_old;
    logic [SW-1:0]                r_rq, n_rq;
    logic [SW-1:0]                r_sq, n_sq;
    logic [PW-1:0]                r_freed, n_freed;
    logic [PW-1:0]                r_cnt, n_cnt;
    logic [PW-1:0]                r_slot, n_slot;

    logic                         r_out_valid, n_out_valid;
    logic [gbnsw_pkg::KIND_W-1:0] r_out_kind, n_out_kind;
    logic                         r_out_acc, n_out_acc;
    logic [PW-1:0]                r_out_slot, n_out_slot;
    logic [SW-1:0]                r_out_rseq, n_out_rseq;
    logic [PW-1:0]                r_out_freed, n_out_freed;
    logic [PW-1:0]                r_out_occ, n_out_occ;
    logic                         r_out_full, n_out_full;
    logic                         r_out_empty, n_out_empty;
    logic                         r_out_last, n_out_last;

    gbnsw_pkg::t_cell_cmd         w_cmd;
    logic [CW:0]                  w_dist;
    logic [SW-1:0]                w_seq   [WINDOW_MAX];
    logic                         w_acked [WINDOW_MAX];

    logic [31:0]                  w_ws32;
    logic [CW-1:0]                w_win;
    logic [CW:0]                  w_space;
    logic [PW-1:0]                w_wm1;
    logic [PW-1:0]                w_ins;
    logic [PW-1:0]                w_old_inc;
    logic [PW-1:0]                w_slot_inc;
    logic [31:0]                  w_sum;
    logic [31:0]                  w_dist32;
    logic                         w_rq_big;
    logic                         w_sq_big;

    // effective window and derived ring arithmetic
    always_comb begin
        w_ws32 = 32'(r_window_size);
        if (w_ws32 < 32'd2) begin
            w_win = CW'(2);
        end else if (w_ws32 > 32'(WINDOW_MAX)) begin
            w_win = CW'(WINDOW_MAX);
        end else begin
            w_win = CW'(r_window_size);
        end
        w_space = {w_win, 1'b0};
        w_wm1   = PW'(32'(w_win) - 32'd1);

        w_sum = 32'(r_old) + 32'(r_occ);
        w_ins = (w_sum >= 32'(w_win)) ? PW'(w_sum - 32'(w_win)) : PW'(w_sum);

        w_old_inc  = (32'(r_old) + 32'd1 >= 32'(w_win)) ? '0 : PW'(32'(r_old) + 32'd1);
        w_slot_inc = (32'(r_slot) + 32'd1 >= 32'(w_win)) ? '0 : PW'(32'(r_slot) + 32'd1);

        w_rq_big = (32'(r_rq) >= 32'(w_space));
        w_sq_big = (32'(r_sq) >= 32'(w_space));
        if (r_rq >= r_sq) begin
            w_dist32 = 32'(r_rq) - 32'(r_sq);
        end else begin
            w_dist32 = 32'(r_rq) + 32'(w_space) - 32'(r_sq);
        end
        w_dist = (CW + 1)'(w_dist32);
    end

    always_comb begin
        n_state       = r_state;
        n_window_size = r_window_size;
        n_occ         = r_occ;
        n_old         = r_old;
        n_rq          = r_rq;
        n_sq          = r_sq;
        n_freed       = r_freed;
        n_cnt         = r_cnt;
        n_slot        = r_slot;
        w_cmd.op      = gbnsw_pkg::CMD_HOLD;
        w_cmd.seq     = i_sequence_req;

        n_out_valid   = 1'b0;
        n_out_kind    = gbnsw_pkg::KIND_SEND;
        n_out_acc     = 1'b0;
        n_out_slot    = '0;
        n_out_rseq    = '0;
        n_out_freed   = '0;
        n_out_occ     = r_occ;
        n_out_last    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_operation)
                        gbnsw_pkg::OP_SEND: begin
                            n_out_valid = 1'b1;
                            n_out_kind  = gbnsw_pkg::KIND_SEND;
                            n_out_last  = 1'b1;
                            if (r_occ != w_wm1) begin
                                w_cmd.op   = gbnsw_pkg::CMD_LOAD;
                                n_out_acc  = 1'b1;
                                n_out_slot = w_ins;
                                n_occ      = r_occ + 1'b1;
                                n_out_occ  = r_occ + 1'b1;
                            end
                        end
                        gbnsw_pkg::OP_ACK: begin
                            n_rq    = i_sequence_req;
                            // an empty ring has no head entry to measure from
                            n_sq    = (r_occ == '0) ? '0 : w_seq[0];
                            n_freed = '0;
                            n_state = S_REDUCE;
                        end
                        gbnsw_pkg::OP_TIMEOUT: begin
                            if (r_occ == '0) begin
                                n_out_valid = 1'b1;
                                n_out_kind  = gbnsw_pkg::KIND_NONE;
                                n_out_last  = 1'b1;
                            end else begin
                                n_cnt   = '0;
                                n_slot  = r_old;
                                n_state = S_RESEND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REDUCE: begin
                // bring both numbers into the sequence space, then mark
                if (w_rq_big) begin
                    n_rq = r_rq - SW'(w_space);
                end
                if (w_sq_big) begin
                    n_sq = r_sq - SW'(w_space);
                end
                if (!w_rq_big && !w_sq_big) begin
                    if (w_dist32 < 32'(w_win)) begin
                        w_cmd.op = gbnsw_pkg::CMD_MARK;
                    end
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                if (r_occ != '0 && w_acked[0]) begin
                    w_cmd.op = gbnsw_pkg::CMD_SHIFT;
                    n_occ    = r_occ - 1'b1;
                    n_old    = w_old_inc;
                    n_freed  = r_freed + 1'b1;
                end else begin
                    n_out_valid = 1'b1;
                    n_out_kind  = gbnsw_pkg::KIND_ACK;
                    n_out_freed = r_freed;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_RESEND: begin
                w_cmd.op    = gbnsw_pkg::CMD_ROTATE;
                n_out_valid = 1'b1;
                n_out_kind  = gbnsw_pkg::KIND_RESEND;
                n_out_slot  = r_slot;
                n_out_rseq  = w_seq[0];
                n_out_last  = (r_cnt == r_occ - 1'b1);
                n_slot      = w_slot_inc;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == r_occ - 1'b1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a window write flushes the ring
        if (i_cfg_wr_en) begin
            n_window_size = i_cfg_wr_data;
            n_occ         = '0;
            n_old         = '0;
        end

        n_out_full  = (n_out_occ == w_wm1);
        n_out_empty = (n_out_occ == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window_size <= gbnsw_pkg::WIN_W'(16);
            r_occ         <= '0;
            r_old         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_window_size <= n_window_size;
            r_occ         <= n_occ;
            r_old         <= n_old;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rq    <= n_rq;
        r_sq    <= n_sq;
        r_freed <= n_freed;
        r_cnt   <= n_cnt;
        r_slot  <= n_slot;
        if (n_out_valid) begin
            r_out_kind  <= n_out_kind;
            r_out_acc   <= n_out_acc;
            r_out_slot  <= n_out_slot;
            r_out_rseq  <= n_out_rseq;
            r_out_freed <= n_out_freed;
            r_out_occ   <= n_out_occ;
            r_out_full  <= n_out_full;
            r_out_empty <= n_out_empty;
            r_out_last  <= n_out_last;
        end
    end

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic [SW-1:0] w_next_seq;
        logic          w_next_acked;

        if (g == WINDOW_MAX - 1) begin : g_tail
            assign w_next_seq   = '0;
            assign w_next_acked = 1'b0;
        end else begin : g_body
            assign w_next_seq   = w_seq[g + 1];
            assign w_next_acked = w_acked[g + 1];
        end

        gbnsw_cell #(
            .IDX (g),
            .PW  (PW),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_occ        (r_occ),
            .i_dist       (w_dist),
            .i_next_seq   (w_next_seq),
            .i_next_acked (w_next_acked),
            .i_head_seq   (w_seq[0]),
            .i_head_acked (w_acked[0]),
            .o_seq        (w_seq[g]),
            .o_acked      (w_acked[g])
        );
    end

    assign busy              = (r_state != S_IDLE);
    assign o_result_valid    = r_out_valid;
    assign o_kind            = r_out_kind;
    assign o_accepted        = r_out_acc;
    assign o_slot            = r_out_slot;
    assign o_resend_sequence = r_out_rseq;
    assign o_freed_count     = r_out_freed;
    assign o_occupancy       = r_out_occ;
    assign o_window_full     = r_out_full;
    assign o_window_empty    = r_out_empty;
    assign o_last            = r_out_last;

endmodule

`default_nettype wire

>>> tb/gbnsw_result_check.sv
// Passive check of the Go-Back-N sender window: mirrors the window state, predicts
// every answer from the command and configuration transactions and compares them.
// Depends on gbnsw_pkg.
`timescale 1ns / 1ps

module gbnsw_result_check #(
    parameter int WINDOW_MAX = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire                              busy,
    input  wire  [gbnsw_pkg::OP_W-1:0]       operation,
    input  wire  [gbnsw_pkg::SEQ_W-1:0]      sequence_req,
    input  wire                              cfg_wr_en,
    input  wire  [gbnsw_pkg::WIN_W-1:0]      cfg_wr_data,
    input  wire                              result_valid,
    input  wire  [gbnsw_pkg::KIND_W-1:0]     kind,
    input  wire                              accepted,
    input  wire  [$clog2(WINDOW_MAX)-1:0]    slot,
    input  wire  [gbnsw_pkg::SEQ_W-1:0]      resend_sequence,
    input  wire  [$clog2(WINDOW_MAX)-1:0]    freed_count,
    input  wire  [$clog2(WINDOW_MAX)-1:0]    occupancy,
    input  wire                              window_full,
    input  wire                              window_empty,
    input  wire                              last,
    output int                               err_count,
    output int                               pending
);
    import gbnsw_pkg::*;

    localparam int SW = $clog2(WINDOW_MAX);
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              accepted;
        logic [SW-1:0]     slot;
        logic [SEQ_W-1:0]  rseq;
        logic [SW-1:0]     freed;
        logic [SW-1:0]     occ;
        logic              full;
        logic              empty;
        logic              last;
    } t_answer;

    logic [SEQ_W-1:0] seq_mem [WINDOW_MAX];
    bit               acked [WINDOW_MAX];
    int unsigned      ins_ptr;
    int unsigned      old_ptr;
    logic [WIN_W-1:0] win_reg;
    t_answer          answers_due [$];
    t_answer          oldest_due;

    function automatic int unsigned eff_window();
        int unsigned w;
        w = win_reg;
        if (w < 2) w = 2;
        if (w > WINDOW_MAX) w = WINDOW_MAX;
        return w;
    endfunction

    function automatic int unsigned in_flight(input int unsigned w);
        return (ins_ptr + w - old_ptr) % w;
    endfunction

    // occupancy and the full/empty flags always reflect the state after the command
    function automatic t_answer make_answer(input logic [KIND_W-1:0] k, input bit acc,
                                            input int unsigned s, input int unsigned rs,
                                            input int unsigned fr, input int unsigned w,
                                            input bit lst);
        t_answer a;
        int unsigned occ;
        occ        = in_flight(w);
        a.kind     = k;
        a.accepted = acc;
        a.slot     = s[SW-1:0];
        a.rseq     = rs[SEQ_W-1:0];
        a.freed    = fr[SW-1:0];
        a.occ      = occ[SW-1:0];
        a.full     = (occ == w - 1);
        a.empty    = (occ == 0);
        a.last     = lst;
        return a;
    endfunction

    task automatic flush_window();
        foreach (acked[i]) acked[i] = 1'b0;
        ins_ptr = 0;
        old_ptr = 0;
    endtask

    task automatic predict_window_answers(input logic [OP_W-1:0] op,
                                          input logic [SEQ_W-1:0] req);
        int unsigned w, occ, span, ack_gap, n, freed, s;
        w     = eff_window();
        occ   = in_flight(w);
        freed = 0;
        case (op)
            OP_SEND: begin
                if (occ == w - 1) begin
                    answers_due.push_back(make_answer(KIND_SEND, 1'b0, 0, 0, 0, w, 1'b1));
                end else begin
                    s = ins_ptr;
                    seq_mem[s] = req;
                    acked[s] = 1'b0;
                    ins_ptr = (s + 1) % w;
                    answers_due.push_back(make_answer(KIND_SEND, 1'b1, s, 0, 0, w, 1'b1));
                end
            end
            OP_ACK: begin
                if (occ > 0) begin
                    span = 2 * w;
                    ack_gap = ((req % span) + span - (seq_mem[old_ptr] % span)) % span;
                    if (ack_gap < w) begin
                        // mark only occupied slots
                        n = (ack_gap + 1 > occ) ? occ : ack_gap + 1;
                        for (int unsigned i = 0; i < n; i++) acked[(old_ptr + i) % w] = 1'b1;
                    end
                end
                while (in_flight(w) > 0 && acked[old_ptr]) begin
                    acked[old_ptr] = 1'b0;
                    old_ptr = (old_ptr + 1) % w;
                    freed++;
                end
                answers_due.push_back(make_answer(KIND_ACK, 1'b0, 0, 0, freed, w, 1'b1));
            end
            OP_TIMEOUT: begin
                if (occ == 0) begin
                    answers_due.push_back(make_answer(KIND_NONE, 1'b0, 0, 0, 0, w, 1'b1));
                end else begin
                    for (int unsigned i = 0; i < occ; i++) begin
                        s = (old_ptr + i) % w;
                        answers_due.push_back(make_answer(KIND_RESEND, 1'b0, s, seq_mem[s],
                                                          0, w, i + 1 == occ));
                    end
                end
            end
            default: ; // unused operation code: no state change, no answer
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTED)
            $display("check @%0t: %s got %0d want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            foreach (seq_mem[i]) seq_mem[i] = '0;
            flush_window();
            win_reg = 5'd16;
            answers_due.delete();
        end else begin
            // answers on the bus now belong to older commands, so compare first
            if (result_valid) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("answer with nothing due, kind", kind, -1);
                end else begin
                    oldest_due = answers_due.pop_front();
                    check_field("kind", kind, oldest_due.kind);
                    check_field("accepted", accepted, oldest_due.accepted);
                    check_field("slot", slot, oldest_due.slot);
                    check_field("resend_sequence", resend_sequence, oldest_due.rseq);
                    check_field("freed_count", freed_count, oldest_due.freed);
                    check_field("occupancy", occupancy, oldest_due.occ);
                    check_field("window_full", window_full, oldest_due.full);
                    check_field("window_empty", window_empty, oldest_due.empty);
                    check_field("last", last, oldest_due.last);
                end
            end
            if (cfg_wr_en) begin
                win_reg = cfg_wr_data;
                flush_window();
            end
            if (start && !busy) predict_window_answers(operation, sequence_req);
        end
        pending = answers_due.size();
    end

endmodule

>>> tb/tb_go_back_n_sender_window.sv
// Testbench top for the Go-Back-N sender window: clock, reset, command and
// configuration stimulus, watchdog and verdict. Depends on gbnsw_pkg,
// go_back_n_sender_window and gbnsw_result_check.
`timescale 1ns / 1ps

module tb_go_back_n_sender_window;
    import gbnsw_pkg::*;

    localparam int WINDOW_MAX     = 16;
    localparam int SW             = $clog2(WINDOW_MAX);
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 8;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [OP_W-1:0]    operation;
    logic [SEQ_W-1:0]   sequence_req;
    logic               cfg_wr_en;
    logic [WIN_W-1:0]   cfg_wr_data;

    logic               busy;
    logic               result_valid;
    logic [KIND_W-1:0]  kind;
    logic               accepted;
    logic [SW-1:0]      slot;
    logic [SEQ_W-1:0]   resend_sequence;
    logic [SW-1:0]      freed_count;
    logic [SW-1:0]      occupancy;
    logic               window_full;
    logic               window_empty;
    logic               last;

    int err_count;
    int pending;
    int stall_cycles;
    int idle_pct;

    // sender-side view of the window, exact for the transactions generated here
    int win_eff;
    int seq_space;
    int next_seq;
    int oldest_seq;
    int unacked;

    logic [WIN_W-1:0] phase_windows [9] = '{5'd0, 5'd16, 5'd1, 5'd7, 5'd17, 5'd3,
                                            5'd31, 5'd2, 5'd12};

    go_back_n_sender_window #(
        .WINDOW_MAX(WINDOW_MAX)
    ) i_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .start(start),
        .busy(busy),
        .i_operation(operation),
        .i_sequence_req(sequence_req),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .o_result_valid(result_valid),
        .o_kind(kind),
        .o_accepted(accepted),
        .o_slot(slot),
        .o_resend_sequence(resend_sequence),
        .o_freed_count(freed_count),
        .o_occupancy(occupancy),
        .o_window_full(window_full),
        .o_window_empty(window_empty),
        .o_last(last)
    );

    gbnsw_result_check #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_result_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .sequence_req(sequence_req),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .result_valid(result_valid),
        .kind(kind),
        .accepted(accepted),
        .slot(slot),
        .resend_sequence(resend_sequence),
        .freed_count(freed_count),
        .occupancy(occupancy),
        .window_full(window_full),
        .window_empty(window_empty),
        .last(last),
        .err_count(err_count),
        .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_valid || cfg_wr_en) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // hold the command until it is taken; returns on the accepting edge
    task automatic issue(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] req);
        start        <= 1'b1;
        operation    <= op;
        sequence_req <= req;
        do @(posedge clk); while (busy);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 99) < idle_pct) pause($urandom_range(1, 6));
    endtask

    // hold off until every predicted answer has arrived
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] value);
        drain();
        // an unused operation gives no answer and leaves the block idle
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        win_eff    = (value < 2) ? 2 : (value > WINDOW_MAX) ? WINDOW_MAX : int'(value);
        seq_space  = 2 * win_eff;
        next_seq   = $urandom_range(0, seq_space - 1);
        oldest_seq = next_seq;
        unacked    = 0;
    endtask

    task automatic random_item();
        int pick;
        int k;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            issue(OP_SEND, SEQ_W'(next_seq));
            if (unacked < win_eff - 1) begin
                unacked++;
                next_seq = (next_seq + 1) % seq_space;
            end
        end else if (pick < 85) begin
            // cumulative ack somewhere in the window, possibly past the newest entry
            k = $urandom_range(0, win_eff - 1);
            issue(OP_ACK, SEQ_W'((oldest_seq + k) % seq_space));
            if (unacked > 0) begin
                n = (k + 1 < unacked) ? k + 1 : unacked;
                unacked -= n;
                oldest_seq = (oldest_seq + n) % seq_space;
            end
        end else if (pick < 95) begin
            issue(OP_TIMEOUT, SEQ_W'($urandom_range(0, 31)));
        end else begin
            case ($urandom_range(0, 2))
                0: issue(OP_UNUSED, SEQ_W'($urandom_range(0, 31)));
                // stale ack: distance lands at or above the window size
                1: issue(OP_ACK, SEQ_W'((oldest_seq + seq_space - 1
                                         - int'($urandom_range(0, win_eff - 1)))
                                        % seq_space));
                default: begin
                    if (unacked == 0) issue(OP_ACK, SEQ_W'($urandom_range(0, 31)));
                    else issue(OP_TIMEOUT, SEQ_W'($urandom_range(0, 31)));
                end
            endcase
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_SEND;
        sequence_req = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        idle_pct     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset window of 16: empty-ring cases, unused operation, stale and long acks
        issue(OP_TIMEOUT, 5'd0);
        issue(OP_ACK, 5'd5);
        issue(OP_UNUSED, 5'd31);
        issue(OP_SEND, 5'd31);
        issue(OP_SEND, 5'd0);
        issue(OP_TIMEOUT, 5'd31);
        issue(OP_ACK, 5'd30);
        issue(OP_ACK, 5'd31);
        issue(OP_ACK, 5'd5);

        // smallest window: full after one entry
        set_window(5'd2);
        issue(OP_SEND, 5'd3);
        issue(OP_SEND, 5'd4);
        issue(OP_TIMEOUT, 5'd0);
        issue(OP_ACK, 5'd3);

        // oversized setting clamps to the largest window; fill it, resend all, free all
        set_window(5'd31);
        for (int i = 0; i < 15; i++) issue(OP_SEND, SEQ_W'((17 + i) % 32));
        issue(OP_SEND, 5'd1);
        issue(OP_TIMEOUT, 5'd0);
        issue(OP_ACK, 5'd31);

        foreach (phase_windows[p]) begin
            idle_pct = (p < 3) ? 17 : (p < 6) ? 81 : 0;
            set_window(phase_windows[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_item();
                maybe_idle();
                if (i == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1) drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
